@@ src/rhps_pkg.sv @@
package rhps_pkg;

    // field widths
    localparam int MODE_W = 2;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 32;
    localparam int HASH_W = 32;

    localparam int MAX_PATTERN_DEF = 32;

    localparam logic [HASH_W-1:0] HASH_BASE = 32'd101;

    // input mode codes (tuser)
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TEXT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // queued command kinds
    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_TEXT   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [1:0]        kind;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic busy;   // back end working on an item
        logic load;   // result loaded into output register this cycle
    } t_back_stat;

endpackage

@@ src/rolling_hash_pattern_search.sv @@
// Channel   Dir  Ports            Contents (low bit up)
// s_axis    in   tdata[7:0]       byte_value
//                tuser[1:0]       mode: 0 append pattern, 1 text, 2 clear, 3 ignored
// m_axis    out  tdata[31:0]      match_position
//
// Pattern append and clear are done by the back end in its idle state; an unused-mode item
// is accepted and dropped by the front end and never reaches the back end.
// A text byte does a window memory read of the outgoing byte, then the hash
// update with one 8x32 multiply against 101^m (only the window write while
// the pattern is empty).
// A hash hit adds a read and a compare state per pattern byte, then a result load.
// Reset is synchronous, active low; no clearing pass is needed.
// A two-item queue decouples the input side from the back end; the back end
// stalls only while a result waits in the full output register.
module rolling_hash_pattern_search #(
    parameter int MAX_PATTERN = rhps_pkg::MAX_PATTERN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [rhps_pkg::BYTE_W-1:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic [rhps_pkg::MODE_W-1:0]  s_axis_tuser,   // [1:0] mode
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [rhps_pkg::POS_W-1:0]   m_axis_tdata    // [31:0] match_position
);
    import rhps_pkg::*;

    t_cmd       cmd;
    logic       cmd_ready;
    t_back_stat stat;

    // front: accept, classify, queue
    rhps_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd         (cmd),
        .i_cmd_ready   (cmd_ready)
    );

    // back: pattern load, rolling hash, verify, result register
    rhps_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res_pos   (m_axis_tdata),
        .o_stat      (stat)
    );

    // a full queue always offers an item to the back end
    a_full_queue_offers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> cmd.valid)
        else $error("queue full but no command offered");

    // a new result appears only after a verified load
    a_result_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(stat.load))
        else $error("result appeared without a verified match");

    // a load always leaves a result pending
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.load |=> m_axis_tvalid)
        else $error("result load lost");

    // back end takes no command while busy
    a_busy_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.busy |-> !cmd_ready)
        else $error("command taken while back end busy");

endmodule

@@ src/rhps_front.sv @@
module rhps_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rhps_pkg::BYTE_W-1:0]   s_axis_tdata,
    input  logic [rhps_pkg::MODE_W-1:0]   s_axis_tuser,
    output rhps_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_ready
);
    import rhps_pkg::*;

    // two-entry command queue
    logic [1:0]        r_q_kind [2];
    logic [BYTE_W-1:0] r_q_data [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_cnt;
    logic              n_wr_ptr;
    logic              n_rd_ptr;
    logic [1:0]        n_cnt;

    logic       push;
    logic       pop;
    logic [1:0] kind;

    always_comb begin
        case (s_axis_tuser)
            MODE_APPEND: kind = KIND_APPEND;
            MODE_TEXT:   kind = KIND_TEXT;
            MODE_CLEAR:  kind = KIND_CLEAR;
            default:     kind = KIND_CLEAR;
        endcase
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    // unused mode is taken and dropped here
    assign push = s_axis_tvalid && s_axis_tready && (s_axis_tuser != MODE_UNUSED);
    assign pop  = o_cmd.valid && i_cmd_ready;

    assign o_cmd.valid = (r_cnt != 2'd0);
    assign o_cmd.kind  = r_q_kind[r_rd_ptr];
    assign o_cmd.data  = r_q_data[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_kind[r_wr_ptr] <= kind;
            r_q_data[r_wr_ptr] <= s_axis_tdata;
        end
    end

endmodule

@@ src/rhps_back.sv @@
module rhps_back #(
    parameter int MAX_PATTERN = rhps_pkg::MAX_PATTERN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rhps_pkg::t_cmd               i_cmd,
    output logic                         o_cmd_ready,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic [rhps_pkg::POS_W-1:0]   o_res_pos,
    output rhps_pkg::t_back_stat         o_stat
);
    import rhps_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [LW-1:0] DEPTH_L = LW'(MAX_PATTERN);
    localparam logic [AW-1:0] LAST_A  = AW'(MAX_PATTERN - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HASH = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    // memories: pattern bytes and circular text window
    logic [BYTE_W-1:0] r_pat [MAX_PATTERN];
    logic [BYTE_W-1:0] r_buf [MAX_PATTERN];
    logic [BYTE_W-1:0] r_pdat;
    logic [BYTE_W-1:0] r_tdat;

    logic [2:0]        r_state,      n_state;
    logic [LW-1:0]     r_len,        n_len;
    logic [HASH_W-1:0] r_phash,      n_phash;
    logic [HASH_W-1:0] r_hp101,      n_hp101;   // 101^len
    logic [HASH_W-1:0] r_thash,      n_thash;
    logic [POS_W-1:0]  r_count,      n_count;
    logic [AW-1:0]     r_wp,         n_wp;
    logic [BYTE_W-1:0] r_byte,       n_byte;
    logic [AW-1:0]     r_leave_addr, n_leave_addr;
    logic              r_leave_ok,   n_leave_ok;
    logic [AW-1:0]     r_taddr,      n_taddr;
    logic [AW-1:0]     r_pidx,       n_pidx;
    logic              r_ov,         n_ov;
    logic [POS_W-1:0]  r_opos,       n_opos;

    logic              pat_we;
    logic              pat_re;
    logic              buf_we;
    logic              buf_re;
    logic [AW-1:0]     buf_raddr;
    logic              load;

    logic [LW-1:0]     wp_ext;
    logic [LW-1:0]     leave_full;
    logic [AW-1:0]     leave_addr;
    logic [AW-1:0]     wp_inc;
    logic [BYTE_W-1:0] leaving;
    logic [HASH_W-1:0] hash_next;
    logic              full;

    // oldest window entry sits len places behind the write pointer
    assign wp_ext     = LW'(r_wp);
    assign leave_full = (wp_ext >= r_len) ? (wp_ext - r_len) : (wp_ext + DEPTH_L - r_len);
    assign leave_addr = leave_full[AW-1:0];
    assign wp_inc     = (r_wp == LAST_A) ? '0 : r_wp + AW'(1);

    // (h - out*101^(m-1))*101 + b  ==  h*101 + b - out*101^m
    assign leaving   = r_leave_ok ? r_tdat : '0;
    assign hash_next = 32'(r_thash * HASH_BASE) + 32'(r_byte)
                     - 32'({24'd0, leaving} * r_hp101);
    assign full      = (r_count >= 32'(r_len));

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = r_ov;
    assign o_res_pos   = r_opos;
    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.load = load;

    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_phash      = r_phash;
        n_hp101      = r_hp101;
        n_thash      = r_thash;
        n_count      = r_count;
        n_wp         = r_wp;
        n_byte       = r_byte;
        n_leave_addr = r_leave_addr;
        n_leave_ok   = r_leave_ok;
        n_taddr      = r_taddr;
        n_pidx       = r_pidx;
        n_ov         = r_ov && !i_res_ready;
        n_opos       = r_opos;
        pat_we       = 1'b0;
        pat_re       = 1'b0;
        buf_we       = 1'b0;
        buf_re       = 1'b0;
        buf_raddr    = leave_addr;
        load         = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    case (i_cmd.kind)
                        KIND_APPEND: begin
                            // full pattern: byte ignored, text kept
                            if (r_len < DEPTH_L) begin
                                pat_we  = 1'b1;
                                n_phash = 32'(r_phash * HASH_BASE) + 32'(i_cmd.data);
                                n_hp101 = (r_len == '0) ? HASH_BASE
                                                        : 32'(r_hp101 * HASH_BASE);
                                n_len   = r_len + LW'(1);
                                n_thash = '0;
                                n_count = '0;
                                n_wp    = '0;
                            end
                        end
                        KIND_TEXT: begin
                            buf_we       = 1'b1;
                            buf_re       = (r_len != '0);
                            n_byte       = i_cmd.data;
                            n_leave_ok   = (r_len != '0) && full;
                            n_leave_addr = leave_addr;
                            n_wp         = wp_inc;
                            n_count      = (r_count == '1) ? r_count : r_count + 32'd1;
                            if (r_len != '0) begin
                                n_state = S_HASH;
                            end
                        end
                        KIND_CLEAR: begin
                            n_len   = '0;
                            n_phash = '0;
                            n_hp101 = 32'd1;
                            n_thash = '0;
                            n_count = '0;
                            n_wp    = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_HASH: begin
                n_thash = hash_next;
                if (full && (hash_next == r_phash)) begin
                    n_taddr = (r_leave_addr == LAST_A) ? '0 : r_leave_addr + AW'(1);
                    n_pidx  = '0;
                    n_state = S_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                buf_re    = 1'b1;
                buf_raddr = r_taddr;
                pat_re    = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                if (r_tdat != r_pdat) begin
                    n_state = S_IDLE;
                end else if (LW'(r_pidx) == (r_len - LW'(1))) begin
                    n_state = S_EMIT;
                end else begin
                    n_pidx  = r_pidx + AW'(1);
                    n_taddr = (r_taddr == LAST_A) ? '0 : r_taddr + AW'(1);
                    n_state = S_RD;
                end
            end
            S_EMIT: begin
                if (!r_ov || i_res_ready) begin
                    load    = 1'b1;
                    n_ov    = 1'b1;
                    n_opos  = r_count - 32'(r_len);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_phash <= '0;
            r_hp101 <= 32'd1;
            r_thash <= '0;
            r_count <= '0;
            r_wp    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_phash <= n_phash;
            r_hp101 <= n_hp101;
            r_thash <= n_thash;
            r_count <= n_count;
            r_wp    <= n_wp;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte       <= n_byte;
        r_leave_addr <= n_leave_addr;
        r_leave_ok   <= n_leave_ok;
        r_taddr      <= n_taddr;
        r_pidx       <= n_pidx;
        r_opos       <= n_opos;
    end

    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            r_pat[r_len[AW-1:0]] <= i_cmd.data;
        end
        if (pat_re) begin
            r_pdat <= r_pat[r_pidx];
        end
        if (buf_we) begin
            r_buf[r_wp] <= i_cmd.data;
        end
        if (buf_re) begin
            r_tdat <= r_buf[buf_raddr];
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import rhps_pkg::*;

    localparam int MAXP         = MAX_PATTERN_DEF;
    localparam int ITEM_TARGET  = 1750;    // items that change state; ignored ones don't count
    localparam int QUIET_LIMIT  = 2000;    // cycles without any handshake before giving up
    localparam int DRAIN_CYCLES = 150;     // covers the longest byte compare and its text update
    localparam int SHOW_LIMIT   = 10;

    // Predicts the match positions of a Rabin-Karp search: base 101, wraps at 2^32,
    // first byte most significant, newest text byte at window[0].
    class match_scoreboard;
        logic [BYTE_W-1:0] pat [MAXP];
        int unsigned       pat_len;
        logic [HASH_W-1:0] pat_hash;
        logic [HASH_W-1:0] top_power;      // 101^(pat_len-1)
        logic [BYTE_W-1:0] window [MAXP];
        logic [HASH_W-1:0] win_hash;
        logic [POS_W-1:0]  text_seen;      // saturates at all ones
        logic [POS_W-1:0]  expected_pos [$];
        int unsigned       errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void restart_text();
            foreach (window[i]) window[i] = '0;
            win_hash  = '0;
            text_seen = '0;
        endfunction

        function void clear_state();
            foreach (pat[i]) pat[i] = '0;
            pat_len   = 0;
            pat_hash  = '0;
            top_power = 32'd1;
            restart_text();
        endfunction

        function int unsigned pending();
            return expected_pos.size();
        endfunction

        // Returns 0 for an item that leaves the block untouched.
        function bit note_input(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] leaving;
            bit                hit;
            case (mode)
                MODE_APPEND: begin
                    if (pat_len >= MAXP)
                        return 1'b0;       // pattern full: byte dropped, text kept
                    pat[pat_len] = b;
                    pat_hash = pat_hash * HASH_BASE + HASH_W'(b);
                    if (pat_len > 0)
                        top_power = top_power * HASH_BASE;
                    pat_len++;
                    restart_text();
                end
                MODE_TEXT: begin
                    leaving = (pat_len > 0) ? window[pat_len-1] : '0;
                    for (int i = MAXP - 1; i > 0; i--)
                        window[i] = window[i-1];
                    window[0] = b;
                    if (text_seen != '1)
                        text_seen++;
                    // empty pattern: bytes are counted but the hash never moves
                    if (pat_len != 0) begin
                        win_hash = (win_hash - HASH_W'(leaving) * top_power) * HASH_BASE
                                   + HASH_W'(b);
                        if (text_seen >= pat_len && win_hash == pat_hash) begin
                            hit = 1'b1;
                            for (int j = 0; j < pat_len; j++)
                                if (window[j] != pat[pat_len-1-j])
                                    hit = 1'b0;
                            if (hit)
                                expected_pos.push_back(text_seen - pat_len);
                        end
                    end
                end
                MODE_CLEAR: clear_state();
                default: return 1'b0;      // unused mode
            endcase
            return 1'b1;
        endfunction

        function void check_result(logic [POS_W-1:0] pos);
            logic [POS_W-1:0] want;
            if (expected_pos.size() == 0) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("%0t: match_position %0d with none expected", $time, pos);
            end else begin
                want = expected_pos.pop_front();
                if (pos !== want) begin
                    errors++;
                    if (errors <= SHOW_LIMIT)
                        $display("%0t: match_position expected %0d got %0d", $time, want, pos);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, block under test
    // ------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [BYTE_W-1:0]   s_axis_tdata  = '0;     // [7:0] byte_value
    logic [MODE_W-1:0]   s_axis_tuser  = MODE_CLEAR; // [1:0] mode
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [POS_W-1:0]    m_axis_tdata;           // [31:0] match_position

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    rolling_hash_pattern_search uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    match_scoreboard sb = new();

    int unsigned send_idle_pct = 22;
    int unsigned recv_idle_pct = 48;
    int unsigned n_items       = 0;
    int unsigned quiet_cycles  = 0;
    bit          in_fire       = 1'b0;
    bit          out_fire      = 1'b0;

    // ------------------------------------------------------------------
    // Monitor. Everything changes at the rising edge only, so the values seen
    // at the falling edge are exactly what the next rising edge will accept.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        in_fire  = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
        // a result can only belong to an older item, so check before noting
        if (out_fire)
            sb.check_result(m_axis_tdata);
        if (in_fire && sb.note_input(s_axis_tuser, s_axis_tdata))
            n_items++;
        if (in_fire || out_fire) begin
            quiet_cycles = 0;
        end else if (++quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stalls drawn every cycle
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Sender tasks. Each is entered at a rising edge and assigns valid exactly
    // once in that step, so valid stays high across back-to-back items.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!in_fire);
    endtask

    // sender pauses until every predicted match has come out
    task automatic hold_off();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte(logic [BYTE_W-1:0] base, int unsigned span);
        return base + BYTE_W'($urandom_range(span - 1));
    endfunction

    // Clear (mostly), load a pattern from a small alphabet, then stream text over
    // the same alphabet with copies of the pattern planted in it. A twisted copy
    // moves one unit of weight between the last two bytes (x-1, y+101): same hash,
    // different bytes, so only the byte compare rejects it.
    task automatic search_scene(input int unsigned plen);
        logic [BYTE_W-1:0] base;
        logic [BYTE_W-1:0] b;
        int unsigned       span;
        int unsigned       n_text;
        int unsigned       len;
        int unsigned       k;
        bit                twist;
        base = BYTE_W'($urandom_range(255));
        span = $urandom_range(2, 4);
        if ($urandom_range(99) < 85)
            send_item(MODE_CLEAR, BYTE_W'($urandom_range(255)));
        repeat (plen) send_item(MODE_APPEND, pick_byte(base, span));
        n_text = $urandom_range(8, 40);
        while (n_text > 0) begin
            k = $urandom_range(99);
            if (k < 25 && sb.pat_len > 0) begin
                len   = sb.pat_len;
                twist = (len >= 2) && (k < 6);
                for (int i = 0; i < len; i++) begin
                    b = sb.pat[i];
                    if (twist && i == len - 2 && sb.pat[i] != 0 && sb.pat[i+1] <= 154)
                        b = b - 1;
                    else if (twist && i == len - 1 && sb.pat[i-1] != 0 && sb.pat[i] <= 154)
                        b = b + 101;
                    send_item(MODE_TEXT, b);
                end
                n_text = (n_text > len) ? n_text - len : 0;
            end else begin
                if (k < 28)        // grows the pattern and restarts the text
                    send_item(MODE_APPEND, pick_byte(base, span));
                else if (k >= 94)
                    send_item(MODE_TEXT, BYTE_W'($urandom_range(255)));
                else
                    send_item(MODE_TEXT, pick_byte(base, span));
                n_text--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned r;
        int unsigned plen;
        int unsigned phase;
        phase = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty pattern: counted, never reported; unused mode does nothing
        send_item(MODE_TEXT, 8'h00);
        send_item(MODE_TEXT, 8'hFF);
        send_item(MODE_UNUSED, 8'hFF);
        // pattern {01,00}: text 00 65 hits the hash but fails the compare,
        // then 01 00 matches at offset 2 with a nonzero byte leaving the window
        send_item(MODE_APPEND, 8'h01);
        send_item(MODE_APPEND, 8'h00);
        send_item(MODE_TEXT, 8'h00);
        send_item(MODE_TEXT, 8'h65);
        send_item(MODE_TEXT, 8'h01);
        send_item(MODE_TEXT, 8'h00);
        send_item(MODE_TEXT, 8'h00);
        // append in mid-text restarts the offset count
        send_item(MODE_APPEND, 8'hFF);
        send_item(MODE_TEXT, 8'h01);
        send_item(MODE_TEXT, 8'h00);
        send_item(MODE_TEXT, 8'hFF);
        // clear, then a one-byte pattern matching back to back
        send_item(MODE_CLEAR, 8'h00);
        send_item(MODE_APPEND, 8'hFF);
        send_item(MODE_TEXT, 8'hFF);
        send_item(MODE_TEXT, 8'hFF);

        // longest pattern with extra appends that must be dropped
        search_scene(MAXP + 2);

        while (n_items < ITEM_TARGET) begin
            if (phase == 0 && n_items >= ITEM_TARGET / 3) begin
                hold_off();
                send_idle_pct = 48;
                recv_idle_pct = 22;
                phase = 1;
            end else if (phase == 1 && n_items >= 2 * ITEM_TARGET / 3) begin
                hold_off();
                send_idle_pct = 0;
                recv_idle_pct = 0;
                phase = 2;
            end
            r = $urandom_range(99);
            if (r < 3) begin
                hold_off();
            end else if (r < 18) begin
                // noise: any mode, any byte
                repeat ($urandom_range(4, 12))
                    send_item(MODE_W'($urandom_range(3)), BYTE_W'($urandom_range(255)));
            end else begin
                r = $urandom_range(99);
                if (r < 4)
                    plen = $urandom_range(MAXP + 1, MAXP + 4);
                else if (r < 10)
                    plen = $urandom_range(12, MAXP);
                else
                    plen = $urandom_range(1, 5);
                search_scene(plen);
            end
        end

        hold_off();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ rolling_hash_pattern_search.f @@
src/rhps_pkg.sv
src/rhps_front.sv
src/rhps_back.sv
src/rolling_hash_pattern_search.sv
tb/tb.sv
